// ===== src/tcf_pkg.sv =====
// shared constants, codes and types of the tilt complementary filter
`default_nettype none
package tcf_pkg;

  localparam int ANGLE_FRAC_BITS = 16;
  localparam int CORDIC_STEPS    = 20;
  localparam int TIME_BITS       = 48;

  localparam int IN_W        = 16;
  localparam int OUT_W       = 25;
  localparam int DT_W        = 48;
  localparam int WEIGHT_W    = 17;
  localparam int COUNTS_W    = 16;
  localparam int FIRST_W     = 20;
  localparam int CFG_W       = 20;
  localparam int CFG_IDX_W   = 2;
  localparam int SQRT_STEPS  = 32;
  localparam int INC_CAP_LOG = 20;
  localparam int CORDIC_W    = 36;
  localparam int TURN_W      = 34;
  localparam int DIVISOR_W   = 36;

  localparam logic [CFG_IDX_W-1:0] CFG_BLEND_WEIGHT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNTS_PER_DPS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_INTERVAL = 2'd2;

  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 17'd64225;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = 17'd65536;
  localparam logic [COUNTS_W-1:0] COUNTS_RESET = 16'd131;
  localparam logic [FIRST_W-1:0]  FIRST_RESET  = 20'd20000;
  localparam logic [FIRST_W-1:0]  US_PER_S     = 20'd1000000;
  localparam logic [63:0]         DT_CAP       = 64'h0000_FFFF_FFFF_FFFF;

  // atan(2^-i) in units of 2^-32 revolution
  localparam logic [29:0] TURN_TABLE [32] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
    30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
    30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
    30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163,
    30'd81, 30'd41, 30'd20, 30'd10, 30'd5, 30'd3, 30'd1, 30'd1, 30'd0
  };

  typedef enum logic [3:0] {
    OP_NONE       = 4'd0,
    OP_LOAD       = 4'd1,
    OP_CORDIC     = 4'd2,
    OP_ROLL_DEG   = 4'd3,
    OP_SQRT       = 4'd4,
    OP_PITCH_LOAD = 4'd5,
    OP_PITCH_DEG  = 4'd6,
    OP_MUL_HI     = 4'd7,
    OP_DIV_INIT   = 4'd8,
    OP_DIV        = 4'd9,
    OP_BLEND_A    = 4'd10,
    OP_BLEND_B    = 4'd11,
    OP_FINISH     = 4'd12
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
    logic out_busy;
  } dp_status_t;

endpackage
`default_nettype wire

// ===== src/tilt_complementary_filter_unit.sv =====
// top level of the tilt complementary filter
// One input word is one five-axis sample (accel x/y/z, gyro x/y, timestamp in us);
// one output word carries the filtered pitch and roll in degrees with
// ANGLE_FRAC_BITS fraction bits. Both channels use valid/ready.
// The block works on one sample at a time. A word is taken only in idle; the
// result is computed by the two sequential CORDIC runs, the 32-step square
// root and the bit-serial gyro divider. The next word is accepted the cycle
// after the result is registered. The output register holds the result while
// the receiver stalls; the next sample is still accepted and computed, and only
// its final state update waits until the pending word is taken.
// Configuration writes (blend weight, gyro counts per deg/s, first interval)
// take effect at once and must be issued while no sample is in flight.
// Reset clears both angles and the stored timestamp (no earlier sample) and
// loads the configuration defaults; the block is ready the cycle after reset.
`default_nettype none
module tilt_complementary_filter_unit #(
  parameter int ANGLE_FRAC_BITS = tcf_pkg::ANGLE_FRAC_BITS,
  parameter int CORDIC_STEPS    = tcf_pkg::CORDIC_STEPS,
  parameter int TIME_BITS       = tcf_pkg::TIME_BITS
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [tcf_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [tcf_pkg::CFG_W-1:0]       cfg_data_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic signed [tcf_pkg::IN_W-1:0] accel_x_i,
  input  wire logic signed [tcf_pkg::IN_W-1:0] accel_y_i,
  input  wire logic signed [tcf_pkg::IN_W-1:0] accel_z_i,
  input  wire logic signed [tcf_pkg::IN_W-1:0] gyro_x_i,
  input  wire logic signed [tcf_pkg::IN_W-1:0] gyro_y_i,
  input  wire logic [TIME_BITS-1:0]            time_us_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic signed [tcf_pkg::OUT_W-1:0]     pitch_deg_o,
  output logic signed [tcf_pkg::OUT_W-1:0]     roll_deg_o
);

  tcf_pkg::dp_cmd_t    cmd;
  tcf_pkg::dp_status_t status;

  tcf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd),
    .st_i       (status)
  );

  tcf_datapath #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
    .CORDIC_STEPS    (CORDIC_STEPS),
    .TIME_BITS       (TIME_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .st_o        (status),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .accel_x_i   (accel_x_i),
    .accel_y_i   (accel_y_i),
    .accel_z_i   (accel_z_i),
    .gyro_x_i    (gyro_x_i),
    .gyro_y_i    (gyro_y_i),
    .time_us_i   (time_us_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .pitch_deg_o (pitch_deg_o),
    .roll_deg_o  (roll_deg_o)
  );

endmodule
`default_nettype wire

// ===== src/tcf_datapath.sv =====
// datapath: cordic, square root, gyro divider, blend and filter state
`default_nettype none
module tcf_datapath #(
  parameter int ANGLE_FRAC_BITS = tcf_pkg::ANGLE_FRAC_BITS,
  parameter int CORDIC_STEPS    = tcf_pkg::CORDIC_STEPS,
  parameter int TIME_BITS       = tcf_pkg::TIME_BITS
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire tcf_pkg::dp_cmd_t                     cmd_i,
  output tcf_pkg::dp_status_t                       st_o,
  input  wire logic                                 cfg_we_i,
  input  wire logic [tcf_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  wire logic [tcf_pkg::CFG_W-1:0]            cfg_data_i,
  input  wire logic signed [tcf_pkg::IN_W-1:0]      accel_x_i,
  input  wire logic signed [tcf_pkg::IN_W-1:0]      accel_y_i,
  input  wire logic signed [tcf_pkg::IN_W-1:0]      accel_z_i,
  input  wire logic signed [tcf_pkg::IN_W-1:0]      gyro_x_i,
  input  wire logic signed [tcf_pkg::IN_W-1:0]      gyro_y_i,
  input  wire logic [TIME_BITS-1:0]                 time_us_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output logic signed [tcf_pkg::OUT_W-1:0]          pitch_deg_o,
  output logic signed [tcf_pkg::OUT_W-1:0]          roll_deg_o
);

  localparam int F     = ANGLE_FRAC_BITS;
  localparam int CW    = tcf_pkg::CORDIC_W;
  localparam int ZW    = tcf_pkg::TURN_W;
  localparam int DW    = tcf_pkg::DIVISOR_W;
  localparam int SW    = 9 + F;
  localparam int QW    = tcf_pkg::INC_CAP_LOG + F;
  localparam int IW    = QW + 2;
  localparam int SIW   = IW + 1;
  localparam int AW    = 10 + F;
  localparam int PW    = SIW + 18;
  localparam int MW    = ZW + 9;
  localparam int MaxSteps = (QW > tcf_pkg::SQRT_STEPS) ? QW : tcf_pkg::SQRT_STEPS;
  localparam int CntW  = $clog2(MaxSteps);

  localparam logic signed [ZW-1:0] HalfTurn = ZW'(64'h8000_0000);
  localparam logic signed [PW-1:0] LimHi = (PW'(1) << (8 + F)) - PW'(1);
  localparam logic signed [PW-1:0] LimLo = -(PW'(1) << (8 + F));
  localparam logic [QW:0] IncCap = {1'b1, {QW{1'b0}}};

  // configuration
  logic [tcf_pkg::WEIGHT_W-1:0] weight_q;
  logic [tcf_pkg::COUNTS_W-1:0] counts_q;
  logic [tcf_pkg::FIRST_W-1:0]  first_q;

  // filter state and control
  logic signed [SW-1:0] roll_q, roll_d, pitch_q, pitch_d;
  logic [TIME_BITS-1:0] prev_q, prev_d;
  logic                 out_valid_q;
  logic [CntW-1:0]      cnt_q, cnt_d;

  // working registers
  logic signed [tcf_pkg::IN_W-1:0] ax_q, ax_d;
  logic [tcf_pkg::IN_W-1:0] gxa_q, gxa_d, gya_q, gya_d;
  logic gxn_q, gxn_d, gyn_q, gyn_d;
  logic [tcf_pkg::DT_W-1:0] dt_q, dt_d;
  logic [30:0] sqa_q, sqa_d, sqb_q, sqb_d;
  logic [DW-1:0] div_q, div_d;
  logic signed [CW-1:0] cx_q, cx_d, cy_q, cy_d;
  logic signed [ZW-1:0] cz_q, cz_d;
  logic chold_q, chold_d;
  logic [63:0] sv_q, sv_d, sr_q, sr_d, sb_q, sb_d;
  logic signed [AW-1:0] accr_q, accr_d, accp_q, accp_d;
  logic [63:0] px_q, px_d, py_q, py_d;
  logic [DW-1:0] rx_q, rx_d, ry_q, ry_d;
  logic [QW-1:0] lox_q, lox_d, loy_q, loy_d, qx_q, qx_d, qy_q, qy_d;
  logic ovx_q, ovx_d, ovy_q, ovy_d;
  logic signed [PW-1:0] pra_q, pra_d, ppa_q, ppa_d, prb_q, prb_d, ppb_q, ppb_d;

  // interval since the previous word
  logic [TIME_BITS-1:0] tdiff;
  logic [63:0] tdiff_w;
  logic [tcf_pkg::DT_W-1:0] dt_new;
  assign tdiff   = time_us_i - prev_q;
  assign tdiff_w = 64'(tdiff);
  always_comb begin
    if (prev_q == '0) begin
      dt_new = tcf_pkg::DT_W'(first_q);
    end else if (tdiff_w > tcf_pkg::DT_CAP) begin
      dt_new = tcf_pkg::DT_CAP[tcf_pkg::DT_W-1:0];
    end else begin
      dt_new = tdiff_w[tcf_pkg::DT_W-1:0];
    end
  end

  logic signed [31:0] ay_sq, az_sq;
  assign ay_sq = accel_y_i * accel_y_i;
  assign az_sq = accel_z_i * accel_z_i;

  logic [tcf_pkg::COUNTS_W-1:0] counts_eff;
  assign counts_eff = (counts_q == '0) ? tcf_pkg::COUNTS_W'(1) : counts_q;

  // cordic load with quadrant fold and the zero-vector case
  logic signed [CW-1:0] ld_x, ld_y, ld_x0, ld_y0;
  logic signed [ZW-1:0] ld_z0;
  logic ld_neg, ld_yz, ld_ypos;
  assign ld_x = (cmd_i.op == tcf_pkg::OP_LOAD) ? CW'($signed({accel_z_i, 16'h0000}))
                                                 : $signed(CW'(sr_q));
  assign ld_y = (cmd_i.op == tcf_pkg::OP_LOAD) ? CW'($signed({accel_y_i, 16'h0000}))
                                                 : CW'($signed({ax_q, 16'h0000}));
  assign ld_neg  = ld_x[CW-1];
  assign ld_yz   = (ld_y == '0);
  assign ld_ypos = !ld_y[CW-1] && !ld_yz;
  assign ld_x0 = (ld_neg && !ld_yz) ? -ld_x : ld_x;
  assign ld_y0 = (ld_neg && !ld_yz) ? -ld_y : ld_y;
  always_comb begin
    if (!ld_neg) begin
      ld_z0 = '0;
    end else if (ld_yz || ld_ypos) begin
      ld_z0 = HalfTurn;
    end else begin
      ld_z0 = -HalfTurn;
    end
  end

  // one cordic micro-rotation
  logic signed [CW-1:0] cdx, cdy, cx_n, cy_n;
  logic signed [ZW-1:0] cturn, cz_n;
  logic cypos;
  assign cdx   = cx_q >>> cnt_q;
  assign cdy   = cy_q >>> cnt_q;
  assign cturn = $signed(ZW'(tcf_pkg::TURN_TABLE[cnt_q[4:0]]));
  assign cypos = !cy_q[CW-1] && (cy_q != '0);
  assign cx_n  = cypos ? cx_q + cdy : cx_q - cdy;
  assign cy_n  = cypos ? cy_q - cdx : cy_q + cdx;
  assign cz_n  = cypos ? cz_q + cturn : cz_q - cturn;

  // turns to degrees, rounded half away from zero
  logic zneg;
  logic [ZW-1:0] zabs;
  logic [MW-1:0] m360, mrnd;
  logic signed [AW-1:0] deg_mag, deg_val;
  assign zneg = cz_q[ZW-1];
  assign zabs = zneg ? ZW'(-cz_q) : ZW'(cz_q);
  assign m360 = (MW'(zabs) << 8) + (MW'(zabs) << 6) + (MW'(zabs) << 5) + (MW'(zabs) << 3);
  assign mrnd = (m360 + (MW'(1) << (31 - F))) >> (32 - F);
  assign deg_mag = $signed(mrnd[AW-1:0]);
  assign deg_val = zneg ? -deg_mag : deg_mag;

  // one square root digit
  logic [63:0] s_rb;
  logic s_ge;
  assign s_rb = sr_q + sb_q;
  assign s_ge = (sv_q >= s_rb);

  // one quotient bit per gyro
  logic [DW:0] rx2, ry2;
  logic gex, gey;
  assign rx2 = {rx_q, lox_q[QW-1]};
  assign ry2 = {ry_q, loy_q[QW-1]};
  assign gex = (rx2 >= {1'b0, div_q});
  assign gey = (ry2 >= {1'b0, div_q});

  logic [63:0] dsh;
  assign dsh = 64'(div_q) << tcf_pkg::INC_CAP_LOG;

  // gyro increments
  logic [QW:0] magx, magy;
  logic signed [IW-1:0] incx, incy;
  assign magx = ovx_q ? IncCap : {1'b0, qx_q};
  assign magy = ovy_q ? IncCap : {1'b0, qy_q};
  assign incx = gxn_q ? -$signed(IW'(magx)) : $signed(IW'(magx));
  assign incy = gyn_q ? -$signed(IW'(magy)) : $signed(IW'(magy));

  // blend
  logic [tcf_pkg::WEIGHT_W-1:0] weff, wcomp;
  logic signed [SIW-1:0] sir, sip;
  logic signed [PW-1:0] sumr, sump, shr, shp, satr, satp;
  assign weff  = (weight_q > tcf_pkg::WEIGHT_ONE) ? tcf_pkg::WEIGHT_ONE : weight_q;
  assign wcomp = tcf_pkg::WEIGHT_ONE - weff;
  assign sir   = SIW'(roll_q) + SIW'(incx);
  assign sip   = SIW'(pitch_q) + SIW'(incy);
  assign sumr  = pra_q + prb_q + PW'(32768);
  assign sump  = ppa_q + ppb_q + PW'(32768);
  assign shr   = sumr >>> 16;
  assign shp   = sump >>> 16;
  assign satr  = (shr < LimLo) ? LimLo : ((shr > LimHi) ? LimHi : shr);
  assign satp  = (shp < LimLo) ? LimLo : ((shp > LimHi) ? LimHi : shp);

  always_comb begin
    roll_d = roll_q; pitch_d = pitch_q; prev_d = prev_q; cnt_d = cnt_q;
    ax_d = ax_q; gxa_d = gxa_q; gya_d = gya_q; gxn_d = gxn_q; gyn_d = gyn_q;
    dt_d = dt_q; sqa_d = sqa_q; sqb_d = sqb_q; div_d = div_q;
    cx_d = cx_q; cy_d = cy_q; cz_d = cz_q; chold_d = chold_q;
    sv_d = sv_q; sr_d = sr_q; sb_d = sb_q; accr_d = accr_q; accp_d = accp_q;
    px_d = px_q; py_d = py_q; rx_d = rx_q; ry_d = ry_q;
    lox_d = lox_q; loy_d = loy_q; qx_d = qx_q; qy_d = qy_q; ovx_d = ovx_q; ovy_d = ovy_q;
    pra_d = pra_q; ppa_d = ppa_q; prb_d = prb_q; ppb_d = ppb_q;
    case (cmd_i.op)
      tcf_pkg::OP_LOAD: begin
        ax_d  = accel_x_i;
        gxn_d = gyro_x_i[tcf_pkg::IN_W-1];
        gyn_d = gyro_y_i[tcf_pkg::IN_W-1];
        gxa_d = gyro_x_i[tcf_pkg::IN_W-1] ? -gyro_x_i : gyro_x_i;
        gya_d = gyro_y_i[tcf_pkg::IN_W-1] ? -gyro_y_i : gyro_y_i;
        dt_d  = dt_new;
        prev_d = time_us_i;
        sqa_d = ay_sq[30:0];
        sqb_d = az_sq[30:0];
        div_d = DW'(counts_eff) * DW'(tcf_pkg::US_PER_S);
        cx_d = ld_x0; cy_d = ld_y0; cz_d = ld_z0; chold_d = ld_yz;
        cnt_d = '0;
      end
      tcf_pkg::OP_CORDIC: begin
        if (!chold_q) begin
          cx_d = cx_n; cy_d = cy_n; cz_d = cz_n;
        end
        cnt_d = cnt_q + CntW'(1);
      end
      tcf_pkg::OP_ROLL_DEG: begin
        accr_d = deg_val;
        sv_d = {32'(sqa_q) + 32'(sqb_q), 32'h0};
        sr_d = '0;
        sb_d = 64'h4000_0000_0000_0000;
        cnt_d = '0;
      end
      tcf_pkg::OP_SQRT: begin
        if (s_ge) begin
          sv_d = sv_q - s_rb;
          sr_d = (sr_q >> 1) + sb_q;
        end else begin
          sr_d = sr_q >> 1;
        end
        sb_d = sb_q >> 2;
        cnt_d = cnt_q + CntW'(1);
      end
      tcf_pkg::OP_PITCH_LOAD: begin
        cx_d = ld_x0; cy_d = ld_y0; cz_d = ld_z0; chold_d = ld_yz;
        cnt_d = '0;
      end
      tcf_pkg::OP_PITCH_DEG: begin
        accp_d = -deg_val;
        px_d = 64'(40'(gxa_q) * 40'(dt_q[23:0]));
        py_d = 64'(40'(gya_q) * 40'(dt_q[23:0]));
      end
      tcf_pkg::OP_MUL_HI: begin
        px_d = px_q + (64'(40'(gxa_q) * 40'(dt_q[47:24])) << 24);
        py_d = py_q + (64'(40'(gya_q) * 40'(dt_q[47:24])) << 24);
      end
      tcf_pkg::OP_DIV_INIT: begin
        ovx_d = (px_q >= dsh);
        ovy_d = (py_q >= dsh);
        rx_d  = px_q[DW+19:20];
        ry_d  = py_q[DW+19:20];
        lox_d = {px_q[19:0], {F{1'b0}}};
        loy_d = {py_q[19:0], {F{1'b0}}};
        qx_d = '0; qy_d = '0;
        cnt_d = '0;
      end
      tcf_pkg::OP_DIV: begin
        rx_d = gex ? DW'(rx2 - {1'b0, div_q}) : rx2[DW-1:0];
        ry_d = gey ? DW'(ry2 - {1'b0, div_q}) : ry2[DW-1:0];
        lox_d = lox_q << 1;
        loy_d = loy_q << 1;
        qx_d = {qx_q[QW-2:0], gex};
        qy_d = {qy_q[QW-2:0], gey};
        cnt_d = cnt_q + CntW'(1);
      end
      tcf_pkg::OP_BLEND_A: begin
        pra_d = PW'(sir) * PW'($signed({1'b0, weff}));
        ppa_d = PW'(sip) * PW'($signed({1'b0, weff}));
      end
      tcf_pkg::OP_BLEND_B: begin
        prb_d = PW'(accr_q) * PW'($signed({1'b0, wcomp}));
        ppb_d = PW'(accp_q) * PW'($signed({1'b0, wcomp}));
      end
      tcf_pkg::OP_FINISH: begin
        roll_d  = satr[SW-1:0];
        pitch_d = satp[SW-1:0];
      end
      default: ;
    endcase
  end

  always_comb begin
    st_o.out_busy = out_valid_q && !out_ready_i;
    case (cmd_i.op)
      tcf_pkg::OP_CORDIC: st_o.last = (cnt_q == CntW'(CORDIC_STEPS - 1));
      tcf_pkg::OP_SQRT:   st_o.last = (cnt_q == CntW'(tcf_pkg::SQRT_STEPS - 1));
      tcf_pkg::OP_DIV:    st_o.last = (cnt_q == CntW'(QW - 1));
      default:            st_o.last = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q    <= tcf_pkg::WEIGHT_RESET;
      counts_q    <= tcf_pkg::COUNTS_RESET;
      first_q     <= tcf_pkg::FIRST_RESET;
      roll_q      <= '0;
      pitch_q     <= '0;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          tcf_pkg::CFG_BLEND_WEIGHT:   weight_q <= cfg_data_i[tcf_pkg::WEIGHT_W-1:0];
          tcf_pkg::CFG_COUNTS_PER_DPS: counts_q <= cfg_data_i[tcf_pkg::COUNTS_W-1:0];
          tcf_pkg::CFG_FIRST_INTERVAL: first_q  <= cfg_data_i[tcf_pkg::FIRST_W-1:0];
          default: ;
        endcase
      end
      roll_q  <= roll_d;
      pitch_q <= pitch_d;
      prev_q  <= prev_d;
      cnt_q   <= cnt_d;
      if (cmd_i.op == tcf_pkg::OP_FINISH) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ax_q <= ax_d; gxa_q <= gxa_d; gya_q <= gya_d; gxn_q <= gxn_d; gyn_q <= gyn_d;
    dt_q <= dt_d; sqa_q <= sqa_d; sqb_q <= sqb_d; div_q <= div_d;
    cx_q <= cx_d; cy_q <= cy_d; cz_q <= cz_d; chold_q <= chold_d;
    sv_q <= sv_d; sr_q <= sr_d; sb_q <= sb_d; accr_q <= accr_d; accp_q <= accp_d;
    px_q <= px_d; py_q <= py_d; rx_q <= rx_d; ry_q <= ry_d;
    lox_q <= lox_d; loy_q <= loy_d; qx_q <= qx_d; qy_q <= qy_d;
    ovx_q <= ovx_d; ovy_q <= ovy_d;
    pra_q <= pra_d; ppa_q <= ppa_d; prb_q <= prb_d; ppb_q <= ppb_d;
  end

  assign out_valid_o = out_valid_q;
  assign pitch_deg_o = tcf_pkg::OUT_W'(pitch_q);
  assign roll_deg_o  = tcf_pkg::OUT_W'(roll_q);

endmodule
`default_nettype wire

// ===== src/tcf_ctrl.sv =====
// sequencer that steps the datapath through one sample
`default_nettype none
module tcf_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  output tcf_pkg::dp_cmd_t         cmd_o,
  input  wire tcf_pkg::dp_status_t st_i
);

  typedef enum logic [12:0] {
    ST_IDLE       = 13'b0000000000001,
    ST_ROLL       = 13'b0000000000010,
    ST_ROLL_DEG   = 13'b0000000000100,
    ST_SQRT       = 13'b0000000001000,
    ST_PITCH_LOAD = 13'b0000000010000,
    ST_PITCH      = 13'b0000000100000,
    ST_PITCH_DEG  = 13'b0000001000000,
    ST_MUL_HI     = 13'b0000010000000,
    ST_DIV_INIT   = 13'b0000100000000,
    ST_DIV        = 13'b0001000000000,
    ST_BLEND_A    = 13'b0010000000000,
    ST_BLEND_B    = 13'b0100000000000,
    ST_FINISH     = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o.op = tcf_pkg::OP_NONE;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = tcf_pkg::OP_LOAD;
          state_d = ST_ROLL;
        end
      end
      ST_ROLL: begin
        cmd_o.op = tcf_pkg::OP_CORDIC;
        if (st_i.last) state_d = ST_ROLL_DEG;
      end
      ST_ROLL_DEG: begin
        cmd_o.op = tcf_pkg::OP_ROLL_DEG;
        state_d = ST_SQRT;
      end
      ST_SQRT: begin
        cmd_o.op = tcf_pkg::OP_SQRT;
        if (st_i.last) state_d = ST_PITCH_LOAD;
      end
      ST_PITCH_LOAD: begin
        cmd_o.op = tcf_pkg::OP_PITCH_LOAD;
        state_d = ST_PITCH;
      end
      ST_PITCH: begin
        cmd_o.op = tcf_pkg::OP_CORDIC;
        if (st_i.last) state_d = ST_PITCH_DEG;
      end
      ST_PITCH_DEG: begin
        cmd_o.op = tcf_pkg::OP_PITCH_DEG;
        state_d = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        cmd_o.op = tcf_pkg::OP_MUL_HI;
        state_d = ST_DIV_INIT;
      end
      ST_DIV_INIT: begin
        cmd_o.op = tcf_pkg::OP_DIV_INIT;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.op = tcf_pkg::OP_DIV;
        if (st_i.last) state_d = ST_BLEND_A;
      end
      ST_BLEND_A: begin
        cmd_o.op = tcf_pkg::OP_BLEND_A;
        state_d = ST_BLEND_B;
      end
      ST_BLEND_B: begin
        cmd_o.op = tcf_pkg::OP_BLEND_B;
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        // the filter state doubles as the output word, so wait for the slot
        if (!st_i.out_busy) begin
          cmd_o.op = tcf_pkg::OP_FINISH;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef ASSERT_OFF
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_ROLL))
    else $error("accepted word did not start the roll rotation");
  a_finish_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH && st_i.out_busy) |=> (state_q == ST_FINISH))
    else $error("left finish while output word was still pending");
  a_finish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == tcf_pkg::OP_FINISH) |-> !st_i.out_busy)
    else $error("state update while output word pending");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (cmd_o.op != tcf_pkg::OP_LOAD))
    else $error("load issued outside idle");
`endif

endmodule
`default_nettype wire
